@@ design/msr_pkg.sv @@
// Shared types and constants for the modular square root core.
package msr_pkg;

  localparam int unsigned ValueWidth   = 64;
  localparam int unsigned ModulusWidth = 32;
  localparam int unsigned CntWidth     = 6;

  typedef struct packed {
    logic [ValueWidth-1:0]   value;
    logic [ModulusWidth-1:0] modulus;
  } in_t;

  typedef struct packed {
    logic [ModulusWidth-1:0] root;
    logic                    status;
  } out_t;

  // Request and response of the shared modular multiplier.
  typedef struct packed {
    logic                    start;
    logic                    use_raw;
    logic [ValueWidth-1:0]   raw;
    logic [ModulusWidth-1:0] a;
    logic [ModulusWidth-1:0] b;
    logic [ModulusWidth-1:0] p;
  } mm_req_t;

  typedef struct packed {
    logic                    done;
    logic [ModulusWidth-1:0] res;
  } mm_rsp_t;

  typedef enum logic [1:0] {
    MM_IDLE,
    MM_MUL,
    MM_RED
  } mm_phase_e;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_CHKV,
    ST_EULER,
    ST_DONE3,
    ST_QS,
    ST_ZTEST,
    ST_ZCHK,
    ST_GOTC,
    ST_GOTT,
    ST_GOTR,
    ST_LOOP,
    ST_OSQ,
    ST_OCHK,
    ST_BSQ,
    ST_UPD1,
    ST_UPD2,
    ST_UPD3,
    ST_POW,
    ST_POWSQ,
    ST_MUL,
    ST_MULW,
    ST_FIN
  } state_e;

  typedef enum logic [2:0] {
    DST_V,
    DST_ACC,
    DST_SQ,
    DST_X,
    DST_B,
    DST_C,
    DST_T,
    DST_R
  } dst_e;

endpackage

@@ design/modular_square_root_prime_core.sv @@
// Top level of the modular square root core: handshakes and result register.
//
//   channel | direction | handshake             | word
//   input   | in        | in_valid_i/in_stall_o | in_data_i (value, modulus)
//   output  | out       | out_valid_o/out_stall_i | out_data_o (root, status)
//
// The time per word is set by the number of modular multiplications, which grows when
// the search for a nonresidue runs long; a modulus below two needs none. Each goes
// through the shared multiplier (issue, one product step, 64 reduction steps, result);
// the first reduction of the value skips the product step.
// The input stalls until the sequencer is back to idle. Reset clears all control state;
// no clearing pass is needed. A finished result waits in the output register while the
// next word is taken.
module modular_square_root_prime_core (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  msr_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output msr_pkg::out_t out_data_o
);

  logic             idle, fin_valid, out_free, load, accept;
  logic             ovalid_q, ovalid_d;
  msr_pkg::out_t    result, odata_q;
  msr_pkg::mm_req_t mm_req;
  msr_pkg::mm_rsp_t mm_rsp;

  assign in_stall_o = !idle;
  assign accept     = in_valid_i && idle;
  assign out_free   = !ovalid_q || !out_stall_i;
  assign load       = fin_valid && out_free;

  always_comb begin
    ovalid_d = ovalid_q;
    if (load)             ovalid_d = 1'b1;
    else if (!out_stall_i) ovalid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovalid_q <= 1'b0;
    end else begin
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      odata_q <= result;
    end
  end

  assign out_valid_o = ovalid_q;
  assign out_data_o  = odata_q;

  msr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (accept),
    .item_i      (in_data_i),
    .fin_ready_i (out_free),
    .mm_rsp_i    (mm_rsp),
    .idle_o      (idle),
    .fin_valid_o (fin_valid),
    .result_o    (result),
    .mm_req_o    (mm_req)
  );

  msr_mulmod u_mulmod (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mm_req),
    .rsp_o  (mm_rsp)
  );

endmodule

@@ design/msr_mulmod.sv @@
// Shared modular multiplier: one 32x32 product (or a raw 64-bit value), then bit-serial reduction.
module msr_mulmod (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  msr_pkg::mm_req_t req_i,
  output msr_pkg::mm_rsp_t rsp_o
);

  msr_pkg::mm_phase_e                    phase_q, phase_d;
  logic [msr_pkg::CntWidth-1:0]          cnt_q, cnt_d;
  logic                                  done_q, done_d;
  logic [msr_pkg::ModulusWidth-1:0]      ma_q, ma_d, mb_q, mb_d;
  logic [msr_pkg::ModulusWidth-1:0]      rem_q, rem_d;
  logic [msr_pkg::ValueWidth-1:0]        prod_q, prod_d;
  logic [msr_pkg::ModulusWidth:0]        rem_sh;

  // Shift in one product bit per cycle; the remainder stays below p.
  assign rem_sh = {rem_q, prod_q[msr_pkg::ValueWidth-1]};

  always_comb begin
    phase_d = phase_q;
    cnt_d   = cnt_q;
    done_d  = 1'b0;
    ma_d    = ma_q;
    mb_d    = mb_q;
    rem_d   = rem_q;
    prod_d  = prod_q;
    unique case (phase_q)
      msr_pkg::MM_IDLE: begin
        if (req_i.start) begin
          ma_d    = req_i.a;
          mb_d    = req_i.b;
          prod_d  = req_i.raw;
          rem_d   = '0;
          cnt_d   = '1;
          phase_d = req_i.use_raw ? msr_pkg::MM_RED : msr_pkg::MM_MUL;
        end
      end
      msr_pkg::MM_MUL: begin
        prod_d  = ma_q * mb_q;
        phase_d = msr_pkg::MM_RED;
      end
      msr_pkg::MM_RED: begin
        if (rem_sh >= {1'b0, req_i.p}) begin
          rem_d = msr_pkg::ModulusWidth'(rem_sh - {1'b0, req_i.p});
        end else begin
          rem_d = rem_sh[msr_pkg::ModulusWidth-1:0];
        end
        prod_d = {prod_q[msr_pkg::ValueWidth-2:0], 1'b0};
        cnt_d  = cnt_q - 1'b1;
        if (cnt_q == '0) begin
          done_d  = 1'b1;
          phase_d = msr_pkg::MM_IDLE;
        end
      end
      default: phase_d = msr_pkg::MM_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= msr_pkg::MM_IDLE;
      done_q  <= 1'b0;
    end else begin
      phase_q <= phase_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_q  <= cnt_d;
    ma_q   <= ma_d;
    mb_q   <= mb_d;
    rem_q  <= rem_d;
    prod_q <= prod_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.res  = rem_q;

`ifndef SYNTH
  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.start |-> phase_q == msr_pkg::MM_IDLE)
    else $error("multiplier started while busy");
  a_res_below_p: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> rem_q < req_i.p)
    else $error("reduced result not below modulus");
`endif

endmodule

@@ design/msr_ctrl.sv @@
// Sequencer for Euler's test, exponentiation and the Tonelli-Shanks loop.
module msr_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  msr_pkg::in_t     item_i,
  input  logic             fin_ready_i,
  input  msr_pkg::mm_rsp_t mm_rsp_i,
  output logic             idle_o,
  output logic             fin_valid_o,
  output msr_pkg::out_t    result_o,
  output msr_pkg::mm_req_t mm_req_o
);

  localparam int unsigned W = msr_pkg::ModulusWidth;
  localparam int unsigned C = msr_pkg::CntWidth;

  msr_pkg::state_e state_q, state_d, mul_ret_q, mul_ret_d, pow_ret_q, pow_ret_d;
  msr_pkg::dst_e   dst_q, dst_d;
  logic [msr_pkg::ValueWidth-1:0] val_q, val_d;
  logic [W-1:0] p_q, p_d, v_q, v_d, acc_q, acc_d, sq_q, sq_d, e_q, e_d;
  logic [W-1:0] q_q, q_d, z_q, z_d, c_q, c_d, t_q, t_d, r_q, r_d;
  logic [W-1:0] x_q, x_d, b_q, b_d, ma_q, ma_d, mb_q, mb_d, root_q, root_d;
  logic [C-1:0] s_q, s_d, m_q, m_d, o_q, o_d, i_q, i_d;
  logic         raw_q, raw_d, status_q, status_d;
  logic [W-1:0] p_m1;
  logic [W:0]   p_p1, q_p1;
  logic [C:0]   io_sum;

  assign p_m1   = p_q - 1'b1;
  assign p_p1   = {1'b0, p_q} + 1'b1;
  assign q_p1   = {1'b0, q_q} + 1'b1;
  assign io_sum = {1'b0, i_q} + {1'b0, o_q} + 1'b1;

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      msr_pkg::ST_IDLE: begin
        if (start_i) begin
          state_d = (item_i.modulus < W'(2)) ? msr_pkg::ST_FIN : msr_pkg::ST_MUL;
        end
      end
      msr_pkg::ST_CHKV: begin
        if (v_q == '0 || p_q == W'(2)) state_d = msr_pkg::ST_FIN;
        else                           state_d = msr_pkg::ST_POW;
      end
      msr_pkg::ST_EULER: begin
        if (acc_q != W'(1))           state_d = msr_pkg::ST_FIN;
        else if (p_q[1:0] == 2'b11)   state_d = msr_pkg::ST_POW;
        else                          state_d = msr_pkg::ST_QS;
      end
      msr_pkg::ST_DONE3: state_d = msr_pkg::ST_FIN;
      msr_pkg::ST_QS: begin
        if (q_q[0] || s_q >= C'(63)) state_d = msr_pkg::ST_ZTEST;
      end
      msr_pkg::ST_ZTEST: begin
        state_d = (z_q >= p_q) ? msr_pkg::ST_FIN : msr_pkg::ST_POW;
      end
      msr_pkg::ST_ZCHK: begin
        state_d = (acc_q == W'(1)) ? msr_pkg::ST_ZTEST : msr_pkg::ST_POW;
      end
      msr_pkg::ST_GOTC: state_d = msr_pkg::ST_POW;
      msr_pkg::ST_GOTT: state_d = msr_pkg::ST_POW;
      msr_pkg::ST_GOTR: state_d = msr_pkg::ST_LOOP;
      msr_pkg::ST_LOOP: begin
        state_d = (t_q == W'(1)) ? msr_pkg::ST_FIN : msr_pkg::ST_OSQ;
      end
      msr_pkg::ST_OSQ: begin
        state_d = (o_q < m_q) ? msr_pkg::ST_MUL : msr_pkg::ST_FIN;
      end
      msr_pkg::ST_OCHK: begin
        state_d = (x_q == W'(1)) ? msr_pkg::ST_BSQ : msr_pkg::ST_OSQ;
      end
      msr_pkg::ST_BSQ: begin
        state_d = (io_sum < {1'b0, m_q}) ? msr_pkg::ST_MUL : msr_pkg::ST_UPD1;
      end
      msr_pkg::ST_UPD1, msr_pkg::ST_UPD2, msr_pkg::ST_UPD3: state_d = msr_pkg::ST_MUL;
      msr_pkg::ST_POW: begin
        if (e_q == '0)  state_d = pow_ret_q;
        else if (e_q[0]) state_d = msr_pkg::ST_MUL;
        else             state_d = msr_pkg::ST_POWSQ;
      end
      msr_pkg::ST_POWSQ: state_d = msr_pkg::ST_MUL;
      msr_pkg::ST_MUL:   state_d = msr_pkg::ST_MULW;
      msr_pkg::ST_MULW: begin
        if (mm_rsp_i.done) state_d = mul_ret_q;
      end
      msr_pkg::ST_FIN: begin
        if (fin_ready_i) state_d = msr_pkg::ST_IDLE;
      end
      default: state_d = msr_pkg::ST_IDLE;
    endcase
  end

  // Datapath registers and outputs.
  always_comb begin
    val_d = val_q;  p_d = p_q;  v_d = v_q;  acc_d = acc_q;  sq_d = sq_q;
    e_d = e_q;  q_d = q_q;  z_d = z_q;  c_d = c_q;  t_d = t_q;  r_d = r_q;
    x_d = x_q;  b_d = b_q;  ma_d = ma_q;  mb_d = mb_q;  root_d = root_q;
    s_d = s_q;  m_d = m_q;  o_d = o_q;  i_d = i_q;  raw_d = raw_q;
    status_d = status_q;  dst_d = dst_q;
    mul_ret_d = mul_ret_q;  pow_ret_d = pow_ret_q;
    unique case (state_q)
      msr_pkg::ST_IDLE: begin
        if (start_i) begin
          val_d     = item_i.value;
          p_d       = item_i.modulus;
          root_d    = '0;
          status_d  = 1'b0;
          raw_d     = 1'b1;
          dst_d     = msr_pkg::DST_V;
          mul_ret_d = msr_pkg::ST_CHKV;
        end
      end
      msr_pkg::ST_CHKV: begin
        if (v_q == '0) begin
          root_d = '0;
        end else if (p_q == W'(2)) begin
          root_d = W'(1);
        end else begin
          acc_d = W'(1);  sq_d = v_q;  e_d = {1'b0, p_m1[W-1:1]};
          pow_ret_d = msr_pkg::ST_EULER;
        end
      end
      msr_pkg::ST_EULER: begin
        if (acc_q != W'(1)) begin
          status_d = 1'b1;
        end else if (p_q[1:0] == 2'b11) begin
          acc_d = W'(1);  sq_d = v_q;  e_d = {1'b0, p_p1[W:2]};
          pow_ret_d = msr_pkg::ST_DONE3;
        end else begin
          q_d = p_m1;  s_d = '0;  z_d = W'(2);
        end
      end
      msr_pkg::ST_DONE3: root_d = acc_q;
      msr_pkg::ST_QS: begin
        if (!(q_q[0] || s_q >= C'(63))) begin
          q_d = {1'b0, q_q[W-1:1]};
          s_d = s_q + 1'b1;
        end
      end
      msr_pkg::ST_ZTEST: begin
        if (z_q >= p_q) begin
          status_d = 1'b1;
        end else begin
          acc_d = W'(1);  sq_d = z_q;  e_d = {1'b0, p_m1[W-1:1]};
          pow_ret_d = msr_pkg::ST_ZCHK;
        end
      end
      msr_pkg::ST_ZCHK: begin
        if (acc_q == W'(1)) begin
          z_d = z_q + 1'b1;
        end else begin
          m_d = s_q;
          acc_d = W'(1);  sq_d = z_q;  e_d = q_q;
          pow_ret_d = msr_pkg::ST_GOTC;
        end
      end
      msr_pkg::ST_GOTC: begin
        c_d = acc_q;
        acc_d = W'(1);  sq_d = v_q;  e_d = q_q;
        pow_ret_d = msr_pkg::ST_GOTT;
      end
      msr_pkg::ST_GOTT: begin
        t_d = acc_q;
        acc_d = W'(1);  sq_d = v_q;  e_d = q_p1[W:1];
        pow_ret_d = msr_pkg::ST_GOTR;
      end
      msr_pkg::ST_GOTR: r_d = acc_q;
      msr_pkg::ST_LOOP: begin
        if (t_q == W'(1)) begin
          root_d = r_q;
        end else begin
          x_d = t_q;  o_d = C'(1);
        end
      end
      msr_pkg::ST_OSQ: begin
        if (o_q < m_q) begin
          raw_d = 1'b0;  ma_d = x_q;  mb_d = x_q;
          dst_d = msr_pkg::DST_X;  mul_ret_d = msr_pkg::ST_OCHK;
        end else begin
          status_d = 1'b1;
        end
      end
      msr_pkg::ST_OCHK: begin
        if (x_q == W'(1)) begin
          b_d = c_q;  i_d = '0;
        end else begin
          o_d = o_q + 1'b1;
        end
      end
      msr_pkg::ST_BSQ: begin
        if (io_sum < {1'b0, m_q}) begin
          i_d = i_q + 1'b1;
          raw_d = 1'b0;  ma_d = b_q;  mb_d = b_q;
          dst_d = msr_pkg::DST_B;  mul_ret_d = msr_pkg::ST_BSQ;
        end
      end
      msr_pkg::ST_UPD1: begin
        m_d = o_q;
        raw_d = 1'b0;  ma_d = b_q;  mb_d = b_q;
        dst_d = msr_pkg::DST_C;  mul_ret_d = msr_pkg::ST_UPD2;
      end
      msr_pkg::ST_UPD2: begin
        raw_d = 1'b0;  ma_d = t_q;  mb_d = c_q;
        dst_d = msr_pkg::DST_T;  mul_ret_d = msr_pkg::ST_UPD3;
      end
      msr_pkg::ST_UPD3: begin
        raw_d = 1'b0;  ma_d = r_q;  mb_d = b_q;
        dst_d = msr_pkg::DST_R;  mul_ret_d = msr_pkg::ST_LOOP;
      end
      msr_pkg::ST_POW: begin
        if (e_q != '0 && e_q[0]) begin
          raw_d = 1'b0;  ma_d = acc_q;  mb_d = sq_q;
          dst_d = msr_pkg::DST_ACC;  mul_ret_d = msr_pkg::ST_POWSQ;
        end
      end
      msr_pkg::ST_POWSQ: begin
        e_d = {1'b0, e_q[W-1:1]};
        raw_d = 1'b0;  ma_d = sq_q;  mb_d = sq_q;
        dst_d = msr_pkg::DST_SQ;  mul_ret_d = msr_pkg::ST_POW;
      end
      msr_pkg::ST_MULW: begin
        if (mm_rsp_i.done) begin
          unique case (dst_q)
            msr_pkg::DST_V:   v_d   = mm_rsp_i.res;
            msr_pkg::DST_ACC: acc_d = mm_rsp_i.res;
            msr_pkg::DST_SQ:  sq_d  = mm_rsp_i.res;
            msr_pkg::DST_X:   x_d   = mm_rsp_i.res;
            msr_pkg::DST_B:   b_d   = mm_rsp_i.res;
            msr_pkg::DST_C:   c_d   = mm_rsp_i.res;
            msr_pkg::DST_T:   t_d   = mm_rsp_i.res;
            msr_pkg::DST_R:   r_d   = mm_rsp_i.res;
            default:          v_d   = v_q;
          endcase
        end
      end
      default: begin
      end
    endcase
    // A failed search always reports a zero root.
    if (status_d) root_d = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= msr_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;  p_q <= p_d;  v_q <= v_d;  acc_q <= acc_d;  sq_q <= sq_d;
    e_q <= e_d;  q_q <= q_d;  z_q <= z_d;  c_q <= c_d;  t_q <= t_d;  r_q <= r_d;
    x_q <= x_d;  b_q <= b_d;  ma_q <= ma_d;  mb_q <= mb_d;  root_q <= root_d;
    s_q <= s_d;  m_q <= m_d;  o_q <= o_d;  i_q <= i_d;  raw_q <= raw_d;
    status_q <= status_d;  dst_q <= dst_d;
    mul_ret_q <= mul_ret_d;  pow_ret_q <= pow_ret_d;
  end

  assign idle_o          = (state_q == msr_pkg::ST_IDLE);
  assign fin_valid_o     = (state_q == msr_pkg::ST_FIN);
  assign result_o.root   = root_q;
  assign result_o.status = status_q;

  assign mm_req_o.start   = (state_q == msr_pkg::ST_MUL);
  assign mm_req_o.use_raw = raw_q;
  assign mm_req_o.raw     = val_q;
  assign mm_req_o.a       = ma_q;
  assign mm_req_o.b       = mb_q;
  assign mm_req_o.p       = p_q;

`ifndef SYNTH
  a_fail_zero_root: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == msr_pkg::ST_FIN && status_q) |-> root_q == '0)
    else $error("non-residue reported with nonzero root");
  a_wait_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mm_rsp_i.done |-> state_q == msr_pkg::ST_MULW)
    else $error("multiplier result arrived outside wait state");
  a_fin_leave: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == msr_pkg::ST_FIN && fin_ready_i) |=> state_q == msr_pkg::ST_IDLE)
    else $error("result handoff did not return to idle");
`endif

endmodule

@@ test/modular_square_root_prime_core_tb.sv @@
// Testbench for the modular square root core: predicted roots checked against every output word.
`timescale 1ns / 1ps

module modular_square_root_prime_core_tb;

  localparam int unsigned CycleLimit = 20000000;
  localparam int unsigned DrainCycles = 200;

  logic          clk_i;
  logic          rst_ni;
  logic          in_valid_i;
  logic          in_stall_o;
  msr_pkg::in_t  in_data_i;
  logic          out_valid_o;
  logic          out_stall_i;
  msr_pkg::out_t out_data_o;

  msr_pkg::out_t root_q[$];
  int unsigned   error_cnt;
  int unsigned   cycle_cnt;
  int unsigned   send_idle_pct;
  int unsigned   recv_stall_pct;
  int unsigned   hold_off_cnt;

  modular_square_root_prime_core u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  function automatic logic [63:0] mul_mod(logic [63:0] a, logic [63:0] b, logic [63:0] p);
    logic [63:0] prod;
    prod = a * b;
    return prod % p;
  endfunction

  function automatic logic [63:0] pow_mod(logic [63:0] base, logic [63:0] e, logic [63:0] p);
    logic [63:0] acc;
    logic [63:0] sq;
    acc = 64'd1 % p;
    sq  = base % p;
    while (e != 0) begin
      if (e[0]) acc = mul_mod(acc, sq, p);
      e  = e >> 1;
      sq = mul_mod(sq, sq, p);
    end
    return acc;
  endfunction

  // Tonelli-Shanks with the smallest nonresidue; returns 0 when no nonresidue or no order is found.
  function automatic bit shanks_root(logic [63:0] v, logic [63:0] p, output logic [63:0] r);
    logic [63:0] q, z, c, t, x, b;
    int unsigned s, m, o, i;
    bit found;
    q = p - 1;
    s = 0;
    r = 0;
    while (q[0] == 1'b0 && s < 63) begin
      q = q >> 1;
      s++;
    end
    z = 2;
    while (z < p && pow_mod(z, (p - 1) >> 1, p) == 1) z++;
    if (z >= p) return 1'b0;
    m = s;
    c = pow_mod(z, q, p);
    t = pow_mod(v, q, p);
    r = pow_mod(v, (q + 1) >> 1, p);
    while (t != 1) begin
      x = t;
      found = 1'b0;
      for (o = 1; o < m; o++) begin
        x = mul_mod(x, x, p);
        if (x == 1) begin
          found = 1'b1;
          break;
        end
      end
      if (!found) return 1'b0;
      b = c;
      for (i = 0; i + o + 1 < m; i++) b = mul_mod(b, b, p);
      m = o;
      c = mul_mod(b, b, p);
      t = mul_mod(t, c, p);
      r = mul_mod(r, b, p);
    end
    return 1'b1;
  endfunction

  function automatic msr_pkg::out_t predict_root(msr_pkg::in_t w);
    msr_pkg::out_t res;
    logic [63:0]   p, v, r;
    logic          status;
    p = {32'd0, w.modulus};
    r = 0;
    status = 1'b0;
    if (p >= 2) begin
      v = w.value % p;
      if (v == 0) begin
        r = 0;
      end else if (p == 2) begin
        r = 1;
      end else if (pow_mod(v, (p - 1) >> 1, p) != 1) begin
        status = 1'b1;
      end else if (p[1:0] == 2'b11) begin
        r = pow_mod(v, (p + 1) >> 2, p);
      end else if (!shanks_root(v, p, r)) begin
        status = 1'b1;
      end
    end
    if (status) r = 0;
    res.root   = r[31:0];
    res.status = status;
    return res;
  endfunction

  function automatic bit prime_test(logic [31:0] n);
    logic [63:0] d;
    if (n < 2) return 1'b0;
    for (d = 2; d * d <= n; d++) begin
      if (n % d == 0) return 1'b0;
    end
    return 1'b1;
  endfunction

  // Random prime of the given bit length; residue_class 1 or 3 picks p mod 4, 0 any.
  function automatic logic [31:0] random_prime(int unsigned bits, int unsigned residue_class);
    logic [31:0] n;
    forever begin
      n = $urandom;
      if (bits < 32) n = n & ((32'd1 << bits) - 1);
      n[bits-1] = 1'b1;
      n[0] = 1'b1;
      if (residue_class != 0) n[1] = (residue_class == 3);
      if (n > 2 && prime_test(n)) return n;
    end
  endfunction

  // A value that is a square mod p, shifted by a random multiple of p.
  function automatic logic [63:0] square_value(logic [31:0] p);
    logic [63:0] x;
    x = {32'd0, $urandom} % p;
    return mul_mod(x, x, p) + {32'd0, p} * {32'd0, $urandom};
  endfunction

  task automatic send_word(logic [63:0] value, logic [31:0] modulus);
    msr_pkg::in_t w;
    w.value   = value;
    w.modulus = modulus;
    while ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk_i);
      in_valid_i = 1'b0;
      in_data_i  = msr_pkg::in_t'({$urandom, $urandom, $urandom});
    end
    @(negedge clk_i);
    in_valid_i = 1'b1;
    in_data_i  = w;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    root_q = {root_q, predict_root(w)};
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (root_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic send_random_word();
    int unsigned pick;
    logic [31:0] p;
    pick = $urandom_range(99);
    if (pick < 60) begin
      p = random_prime($urandom_range(12, 3), $urandom_range(3, 0) == 0 ? 3 : 1);
      send_word($urandom_range(1) ? square_value(p) : {$urandom, $urandom}, p);
    end else if (pick < 78) begin
      p = random_prime(32, $urandom_range(1) ? 1 : 3);
      send_word($urandom_range(1) ? square_value(p) : {$urandom, $urandom}, p);
    end else if (pick < 86) begin
      p = random_prime($urandom_range(16, 3), 0);
      send_word({32'd0, p} * {32'd0, $urandom}, p);
    end else if (pick < 92) begin
      send_word({$urandom, $urandom}, $urandom_range(2) == 0 ? 32'd2 : $urandom_range(1));
    end else begin
      // Arbitrary, often composite modulus, small half the time so the result stays bounded in time.
      send_word({$urandom, $urandom}, $urandom_range(1) ? $urandom_range(4000, 4) : $urandom);
    end
  endtask

  task automatic test_directed();
    logic [31:0] p;
    send_word(64'd0, 32'd0);
    send_word(64'hFFFF_FFFF_FFFF_FFFF, 32'd0);
    send_word(64'hFFFF_FFFF_FFFF_FFFF, 32'd1);
    send_word(64'd0, 32'd2);
    send_word(64'hFFFF_FFFF_FFFF_FFFF, 32'd2);
    send_word(64'd2, 32'd3);
    send_word(64'd1, 32'd3);
    send_word(64'd4, 32'd5);
    send_word(64'd2, 32'd5);
    send_word(64'd2, 32'd17);
    send_word(64'd13, 32'd17);
    send_word(64'd10, 32'd13);
    send_word(64'd3 * 64'd41, 32'd41);
    send_word(64'hFFFF_FFFF_FFFF_FFFF, 32'd4294967291);
    send_word(64'd4, 32'd4294967291);
    p = random_prime(32, 1);
    send_word(square_value(p), p);
    send_word(64'hFFFF_FFFF_FFFF_FFFF, p);
    send_word(64'd4, 32'd15);
    send_word(64'd2, 32'd21);
    send_word(64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF);
    send_word(64'hAAAA_AAAA_5555_5555, 32'd257);
    wait_drained();
  endtask

  task automatic test_random(int unsigned idle_pct, int unsigned stall_pct, int unsigned count);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    repeat (count) send_random_word();
    wait_drained();
  endtask

  // Output held off while the sender keeps offering, so the input must stall.
  task automatic test_backpressure();
    logic [31:0] p;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_off_cnt   = 30000;
    repeat (5) begin
      p = random_prime($urandom_range(8, 3), 0);
      send_word(square_value(p), p);
    end
    wait_drained();
  endtask

  always @(negedge clk_i) begin
    if (hold_off_cnt != 0) begin
      out_stall_i = 1'b1;
      hold_off_cnt--;
    end else begin
      out_stall_i = ($urandom_range(99) < recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    msr_pkg::out_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (root_q.size() == 0) begin
        $display("%0t: output word with none expected: root %0d status %0d", $time,
                 out_data_o.root, out_data_o.status);
        error_cnt++;
      end else begin
        want = root_q.pop_front();
        if (out_data_o.root !== want.root) begin
          $display("%0t: root mismatch: expected %0d actual %0d", $time, want.root,
                   out_data_o.root);
          error_cnt++;
        end
        if (out_data_o.status !== want.status) begin
          $display("%0t: status mismatch: expected %0d actual %0d", $time, want.status,
                   out_data_o.status);
          error_cnt++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CycleLimit) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    error_cnt      = 0;
    cycle_cnt      = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_off_cnt   = 0;
    in_valid_i     = 1'b0;
    in_data_i      = '0;
    out_stall_i    = 1'b0;
    rst_ni         = 1'b0;
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;

    test_directed();
    test_random(0, 0, 20);
    test_random(58, 0, 20);
    test_random(0, 58, 20);
    test_random(19, 19, 20);
    test_backpressure();

    repeat (DrainCycles) @(posedge clk_i);
    if (error_cnt == 0 && root_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

@@ modular_square_root_prime_core.f @@
design/msr_pkg.sv
design/msr_mulmod.sv
design/msr_ctrl.sv
design/modular_square_root_prime_core.sv
test/modular_square_root_prime_core_tb.sv
